>>> design/kmeans_cluster_engine_core_defines.svh
// assertion macros used by the k-means engine controller
`ifndef KMEANS_CLUSTER_ENGINE_CORE_DEFINES_SVH
`define KMEANS_CLUSTER_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define KCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define KCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/kce_pkg.sv
// shared constants, codes and control structs of the k-means engine
package kce_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;

  localparam int ITER_W     = 10;
  localparam int ITER_RESET = 100;
  localparam int K_RESET    = 2;
  localparam int ND_RESET   = 2;

  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_PT   = 3'd0,
    OP_LOAD_CENT = 3'd1,
    OP_RUN       = 3'd2,
    OP_READ_ASG  = 3'd3,
    OP_READ_CENT = 3'd4,
    OP_CLEAR     = 3'd5
  } kce_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } kce_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_NUM_DIMS     = 2'd1,
    CFG_ITERS        = 2'd2
  } kce_cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic resp;
    logic pass_init;
    logic dist_acc;
    logic dist_cmp;
    logic asg_wr;
    logic acc_wr;
    logic upd_mode;
    logic div_start;
    logic upd_wr;
  } kce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_go;
    logic last_p;
    logic cnt_zero;
    logic div_done;
  } kce_sts_t;

endpackage

>>> design/kce_div.sv
// restoring divider, one quotient bit per cycle
module kce_div #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (run_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(DVD_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> design/kce_dpath.sv
// k-means datapath: stores, distance unit, accumulators, mean update
module kce_dpath #(
  parameter int MAX_POINTS   = kce_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = kce_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = kce_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_WIDTH  = kce_pkg::COORD_WIDTH_DEF,
  localparam int PW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_CLUSTERS),
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int KW    = $clog2(MAX_CLUSTERS + 1),
  localparam int NDW   = $clog2(MAX_DIMS + 1),
  localparam int IDX_W = (PW > CW) ? PW : CW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kce_pkg::kce_cmd_t              cmd,
  output kce_pkg::kce_sts_t              sts,
  input  logic [PW-1:0]                  p_idx,
  input  logic [CW-1:0]                  c_idx,
  input  logic [DW-1:0]                  d_idx,
  input  logic [KW-1:0]                  k,
  input  logic [NDW-1:0]                 nd,
  input  logic [kce_pkg::OP_W-1:0]       in_op,
  input  logic [IDX_W-1:0]               in_item_index,
  input  logic [DW-1:0]                  in_dim_index,
  input  logic signed [COORD_WIDTH-1:0]  in_coord_value,
  output logic                           out_valid,
  output logic [kce_pkg::STATUS_W-1:0]   out_status,
  output logic signed [COORD_WIDTH-1:0]  out_read_value,
  output logic [CW-1:0]                  out_cluster_id,
  output logic [CNT_W-1:0]               out_points_loaded
);

  localparam int SUM_W    = COORD_WIDTH + PW + 1;
  localparam int SQ_W     = 2 * COORD_WIDTH + 2;
  localparam int DIST_W   = SQ_W + DW;
  localparam int PT_DEPTH = MAX_POINTS << DW;
  localparam int CT_DEPTH = MAX_CLUSTERS << DW;

  logic [COORD_WIDTH-1:0] pt_mem  [PT_DEPTH];
  logic [COORD_WIDTH-1:0] ct_mem  [CT_DEPTH];
  logic [SUM_W-1:0]       sum_mem [CT_DEPTH];
  logic [CW-1:0]          asg_mem [MAX_POINTS];
  logic [CNT_W-1:0]       cnt_r   [MAX_CLUSTERS];

  logic [PW-1:0]          in_pidx;
  logic [CW-1:0]          in_cidx;
  logic                   pt_idx_ok, cl_idx_ok, dim_ok, asg_ok;
  kce_pkg::kce_status_t   st_nxt, st_r;
  logic [kce_pkg::OP_W-1:0] op_r;
  logic                   run_go_r;
  logic [CNT_W-1:0]       total_r;

  logic [COORD_WIDTH-1:0] pt_rd_r, ct_rd_r;
  logic [SUM_W-1:0]       sum_rd_r;
  logic [CW-1:0]          asg_rd_r;

  logic                   ld_pt, ld_ct;
  logic                   ct_we;
  logic [CW+DW-1:0]       ct_waddr, ct_raddr, sum_raddr;
  logic [COORD_WIDTH-1:0] ct_wdata;

  logic signed [COORD_WIDTH:0] diff;
  logic signed [SQ_W-1:0] prod;
  logic [SQ_W-1:0]        sq_r;
  logic [DIST_W-1:0]      dist_r, best_dist_r;
  logic [CW-1:0]          best_r;
  logic                   first_r;

  logic [CW-1:0]          cnt_sel;
  logic [CNT_W-1:0]       cnt_rd;
  logic [SUM_W-1:0]       pt_ext, sum_mag, quo, quo_s;
  logic                   neg_r, div_done;

  assign in_pidx   = PW'(in_item_index);
  assign in_cidx   = CW'(in_item_index);
  assign pt_idx_ok = 32'(in_item_index) < 32'(MAX_POINTS);
  assign cl_idx_ok = 32'(in_item_index) < 32'(k);
  assign dim_ok    = NDW'(in_dim_index) < nd;
  assign asg_ok    = 32'(in_item_index) < 32'(total_r);

  always_comb begin
    st_nxt = kce_pkg::ST_OK;
    unique case (in_op)
      kce_pkg::OP_LOAD_PT:
        if (!pt_idx_ok || !dim_ok) st_nxt = kce_pkg::ST_RANGE;
      kce_pkg::OP_LOAD_CENT, kce_pkg::OP_READ_CENT:
        if (!cl_idx_ok || !dim_ok) st_nxt = kce_pkg::ST_RANGE;
      kce_pkg::OP_RUN:
        if (total_r == '0) st_nxt = kce_pkg::ST_EMPTY;
      kce_pkg::OP_READ_ASG:
        if (!asg_ok) st_nxt = kce_pkg::ST_RANGE;
      default: st_nxt = kce_pkg::ST_OK;
    endcase
  end

  assign ld_pt = cmd.accept && (in_op == kce_pkg::OP_LOAD_PT) && (st_nxt == kce_pkg::ST_OK);
  assign ld_ct = cmd.accept && (in_op == kce_pkg::OP_LOAD_CENT) && (st_nxt == kce_pkg::ST_OK);

  // item capture and point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      run_go_r <= 1'b0;
    end else if (cmd.accept) begin
      run_go_r <= (in_op == kce_pkg::OP_RUN) && (total_r != '0);
      if (in_op == kce_pkg::OP_CLEAR) total_r <= '0;
      else if (ld_pt && (CNT_W'(in_pidx) + CNT_W'(1) > total_r))
        total_r <= CNT_W'(in_pidx) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_op;
      st_r <= st_nxt;
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (ld_pt) pt_mem[{in_pidx, in_dim_index}] <= in_coord_value;
    pt_rd_r <= pt_mem[{p_idx, d_idx}];
  end

  // centroid store
  assign ct_we    = ld_ct || cmd.upd_wr;
  assign ct_waddr = cmd.upd_wr ? {c_idx, d_idx} : {in_cidx, in_dim_index};
  assign ct_wdata = cmd.upd_wr ? quo_s[COORD_WIDTH-1:0] : in_coord_value;
  assign ct_raddr = cmd.accept ? {in_cidx, in_dim_index} : {c_idx, d_idx};

  always_ff @(posedge clk) begin
    if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
    ct_rd_r <= ct_mem[ct_raddr];
  end

  // assignment store, zeroed by the sweep after reset
  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.asg_wr) asg_mem[p_idx] <= cmd.clr_wr ? '0 : best_r;
    asg_rd_r <= asg_mem[in_pidx];
  end

  // distance of one point to one centroid
  assign diff = $signed({ct_rd_r[COORD_WIDTH-1], ct_rd_r})
              - $signed({pt_rd_r[COORD_WIDTH-1], pt_rd_r});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    sq_r <= $unsigned(prod);
    if (cmd.dist_acc) dist_r <= ((d_idx == '0) ? '0 : dist_r) + DIST_W'(sq_r);
    if (cmd.dist_cmp && ((c_idx == '0) || (dist_r < best_dist_r))) begin
      best_dist_r <= dist_r;
      best_r      <= c_idx;
    end
  end

  // member counts
  assign cnt_sel = cmd.upd_mode ? c_idx : best_r;
  assign cnt_rd  = cnt_r[cnt_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt_r[i] <= '0;
    end else if (cmd.pass_init) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt_r[i] <= '0;
    end else if (cmd.asg_wr) begin
      cnt_r[best_r] <= cnt_rd + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.asg_wr) first_r <= (cnt_rd == '0);
  end

  // coordinate sums, a row counts as empty until its cluster gets a member
  assign pt_ext    = {{(SUM_W-COORD_WIDTH){pt_rd_r[COORD_WIDTH-1]}}, pt_rd_r};
  assign sum_raddr = cmd.upd_mode ? {c_idx, d_idx} : {best_r, d_idx};

  always_ff @(posedge clk) begin
    if (cmd.acc_wr) sum_mem[{best_r, d_idx}] <= first_r ? pt_ext : sum_rd_r + pt_ext;
    sum_rd_r <= sum_mem[sum_raddr];
  end

  // mean, truncated toward zero
  assign sum_mag = sum_rd_r[SUM_W-1] ? SUM_W'(0) - sum_rd_r : sum_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= sum_rd_r[SUM_W-1];
  end

  kce_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (cnt_rd),
    .quotient (quo),
    .done     (div_done)
  );

  assign quo_s = neg_r ? SUM_W'(0) - quo : quo;

  assign sts.run_go   = run_go_r;
  assign sts.last_p   = CNT_W'(p_idx) == total_r - CNT_W'(1);
  assign sts.cnt_zero = cnt_rd == '0;
  assign sts.div_done = div_done;

  // result registers
  logic                   out_valid_r;
  kce_pkg::kce_status_t   out_status_r;
  logic [COORD_WIDTH-1:0] out_read_value_r;
  logic [CW-1:0]          out_cluster_id_r;
  logic [CNT_W-1:0]       out_points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.resp;
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_status_r     <= st_r;
      out_read_value_r <= ((op_r == kce_pkg::OP_READ_CENT) && (st_r == kce_pkg::ST_OK))
                          ? ct_rd_r : '0;
      out_cluster_id_r <= ((op_r == kce_pkg::OP_READ_ASG) && (st_r == kce_pkg::ST_OK))
                          ? asg_rd_r : '0;
      out_points_r     <= total_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_read_value_r;
  assign out_cluster_id    = out_cluster_id_r;
  assign out_points_loaded = out_points_r;

endmodule

>>> design/kce_ctrl.sv
// k-means controller: item sequencing, pass loops and clearing sweep
`include "kmeans_cluster_engine_core_defines.svh"

module kce_ctrl #(
  parameter int MAX_POINTS   = kce_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = kce_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = kce_pkg::MAX_CLUSTERS_DEF,
  localparam int PW  = $clog2(MAX_POINTS),
  localparam int CW  = $clog2(MAX_CLUSTERS),
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int KW  = $clog2(MAX_CLUSTERS + 1),
  localparam int NDW = $clog2(MAX_DIMS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [KW-1:0]              k,
  input  logic [NDW-1:0]             nd,
  input  logic [kce_pkg::ITER_W-1:0] iters,
  input  kce_pkg::kce_sts_t          sts,
  output kce_pkg::kce_cmd_t          cmd,
  output logic [PW-1:0]              p_idx,
  output logic [CW-1:0]              c_idx,
  output logic [DW-1:0]              d_idx
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_CLR      = 17'h00002,
    S_DEC      = 17'h00004,
    S_PASS     = 17'h00008,
    S_DIST_RD  = 17'h00010,
    S_DIST_SQ  = 17'h00020,
    S_DIST_ACC = 17'h00040,
    S_DIST_CMP = 17'h00080,
    S_ASG      = 17'h00100,
    S_ACC_RD   = 17'h00200,
    S_ACC_WR   = 17'h00400,
    S_UPD_C    = 17'h00800,
    S_UPD_RD   = 17'h01000,
    S_UPD_GO   = 17'h02000,
    S_UPD_WAIT = 17'h04000,
    S_UPD_WR   = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PW-1:0]              p_r, p_nxt;
  logic [CW-1:0]              c_r, c_nxt;
  logic [DW-1:0]              d_r, d_nxt;
  logic [kce_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic                       last_d, last_c;

  assign last_d = NDW'(d_r) == nd - NDW'(1);
  assign last_c = KW'(c_r) == k - KW'(1);

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (p_r == PW'(MAX_POINTS - 1)) begin
          p_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          p_nxt = p_r + PW'(1);
        end
      end
      S_DEC: begin
        if (sts.run_go) begin
          iter_nxt  = '0;
          state_nxt = S_PASS;
        end else begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PASS: begin
        if (iter_r == iters) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pass_init = 1'b1;
          p_nxt         = '0;
          c_nxt         = '0;
          d_nxt         = '0;
          state_nxt     = S_DIST_RD;
        end
      end
      S_DIST_RD: state_nxt = S_DIST_SQ;
      S_DIST_SQ: state_nxt = S_DIST_ACC;
      S_DIST_ACC: begin
        cmd.dist_acc = 1'b1;
        if (last_d) begin
          state_nxt = S_DIST_CMP;
        end else begin
          d_nxt     = d_r + DW'(1);
          state_nxt = S_DIST_RD;
        end
      end
      S_DIST_CMP: begin
        cmd.dist_cmp = 1'b1;
        d_nxt        = '0;
        if (last_c) begin
          state_nxt = S_ASG;
        end else begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_DIST_RD;
        end
      end
      S_ASG: begin
        cmd.asg_wr = 1'b1;
        state_nxt  = S_ACC_RD;
      end
      S_ACC_RD: state_nxt = S_ACC_WR;
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        if (!last_d) begin
          d_nxt     = d_r + DW'(1);
          state_nxt = S_ACC_RD;
        end else begin
          c_nxt = '0;
          d_nxt = '0;
          if (sts.last_p) begin
            state_nxt = S_UPD_C;
          end else begin
            p_nxt     = p_r + PW'(1);
            state_nxt = S_DIST_RD;
          end
        end
      end
      S_UPD_C: begin
        cmd.upd_mode = 1'b1;
        if (sts.cnt_zero) begin
          if (last_c) begin
            iter_nxt  = iter_r + kce_pkg::ITER_W'(1);
            state_nxt = S_PASS;
          end else begin
            c_nxt = c_r + CW'(1);
          end
        end else begin
          d_nxt     = '0;
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        cmd.upd_mode = 1'b1;
        state_nxt    = S_UPD_GO;
      end
      S_UPD_GO: begin
        cmd.upd_mode  = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        cmd.upd_mode = 1'b1;
        if (sts.div_done) state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_mode = 1'b1;
        cmd.upd_wr   = 1'b1;
        if (!last_d) begin
          d_nxt     = d_r + DW'(1);
          state_nxt = S_UPD_RD;
        end else if (last_c) begin
          iter_nxt  = iter_r + kce_pkg::ITER_W'(1);
          state_nxt = S_PASS;
        end else begin
          c_nxt     = c_r + CW'(1);
          d_nxt     = '0;
          state_nxt = S_UPD_C;
        end
      end
      S_DONE: begin
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      p_r     <= '0;
      c_r     <= '0;
      d_r     <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
      iter_r  <= iter_nxt;
    end
  end

  assign busy  = state_r != S_IDLE;
  assign p_idx = p_r;
  assign c_idx = c_r;
  assign d_idx = d_r;

  `KCE_ASSERT_IMPL(a_dim_in_range, state_r == S_DIST_ACC, NDW'(d_r) < nd, "dimension counter past num_dims")
  `KCE_ASSERT_IMPL(a_cluster_in_range, state_r == S_DIST_CMP, KW'(c_r) < k, "cluster counter past num_clusters")
  `KCE_ASSERT_IMPL(a_write_after_div, state_r == S_UPD_WR, sts.div_done, "centroid written before quotient ready")
  `KCE_ASSERT_NEXT(a_resp_then_idle, cmd.resp, state_r == S_IDLE, "no return to idle after a result")

endmodule

>>> design/kmeans_cluster_engine_core.sv
// k-means engine top level: configuration registers, controller and datapath
// load, read and clear items: the item and its status are registered on accept, the controller
//   raises resp in its decode state and the result strobe follows; the next item is taken in idle
// run items: each pass loops over the points for the distance and sum loops, then divides the
//   sums of each non-empty cluster with the bit-serial divider and skips each empty one
// reset: after rst_n rises busy stays high while the assignment store is swept to zero;
//   configuration writes are taken at any time; the receiver cannot stall
module kmeans_cluster_engine_core #(
  parameter int MAX_POINTS   = kce_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = kce_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = kce_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_WIDTH  = kce_pkg::COORD_WIDTH_DEF,
  localparam int PW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_CLUSTERS),
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int KW    = $clog2(MAX_CLUSTERS + 1),
  localparam int NDW   = $clog2(MAX_DIMS + 1),
  localparam int IDX_W = (PW > CW) ? PW : CW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  logic [kce_pkg::OP_W-1:0]        in_op,
  input  logic [IDX_W-1:0]                in_item_index,
  input  logic [DW-1:0]                   in_dim_index,
  input  logic signed [COORD_WIDTH-1:0]   in_coord_value,
  // result channel
  output logic                            out_valid,
  output logic [kce_pkg::STATUS_W-1:0]    out_status,
  output logic signed [COORD_WIDTH-1:0]   out_read_value,
  output logic [CW-1:0]                   out_cluster_id,
  output logic [CNT_W-1:0]                out_points_loaded,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kce_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // raw register values, saturated into range where they are used
  logic [KW-1:0]              num_clusters_r;
  logic [NDW-1:0]             num_dims_r;
  logic [kce_pkg::ITER_W-1:0] iteration_count_r;
  logic [KW-1:0]              k_eff;
  logic [NDW-1:0]             nd_eff;
  logic                       cfg_we;

  // register port never backpressures
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r    <= KW'(kce_pkg::K_RESET);
      num_dims_r        <= NDW'(kce_pkg::ND_RESET);
      iteration_count_r <= kce_pkg::ITER_W'(kce_pkg::ITER_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        kce_pkg::CFG_NUM_CLUSTERS: num_clusters_r    <= cfg_data[KW-1:0];
        kce_pkg::CFG_NUM_DIMS:     num_dims_r        <= cfg_data[NDW-1:0];
        kce_pkg::CFG_ITERS:        iteration_count_r <= cfg_data[kce_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp cluster and dimension counts into 1..max
  always_comb begin
    if (num_clusters_r == '0)                      k_eff = KW'(1);
    else if (num_clusters_r > KW'(MAX_CLUSTERS))   k_eff = KW'(MAX_CLUSTERS);
    else                                           k_eff = num_clusters_r;
    if (num_dims_r == '0)                          nd_eff = NDW'(1);
    else if (num_dims_r > NDW'(MAX_DIMS))          nd_eff = NDW'(MAX_DIMS);
    else                                           nd_eff = num_dims_r;
  end

  kce_pkg::kce_cmd_t cmd;
  kce_pkg::kce_sts_t sts;
  logic [PW-1:0]     p_idx;
  logic [CW-1:0]     c_idx;
  logic [DW-1:0]     d_idx;

  // sequencer: item decode, pass loops over points, clusters and dims
  kce_ctrl #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_DIMS     (MAX_DIMS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .k     (k_eff),
    .nd    (nd_eff),
    .iters (iteration_count_r),
    .sts   (sts),
    .cmd   (cmd),
    .p_idx (p_idx),
    .c_idx (c_idx),
    .d_idx (d_idx)
  );

  // stores, squared-distance unit, sum accumulation and mean divider
  kce_dpath #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_DIMS     (MAX_DIMS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .p_idx             (p_idx),
    .c_idx             (c_idx),
    .d_idx             (d_idx),
    .k                 (k_eff),
    .nd                (nd_eff),
    .in_op             (in_op),
    .in_item_index     (in_item_index),
    .in_dim_index      (in_dim_index),
    .in_coord_value    (in_coord_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_cluster_id    (out_cluster_id),
    .out_points_loaded (out_points_loaded)
  );

endmodule
